// ===== hw/rtl/sobel_gradient_magnitude_direction_top_assert.svh =====
// assertion helpers for the sobel gradient block
`ifndef SOBEL_GRADIENT_MAGNITUDE_DIRECTION_TOP_ASSERT_SVH
`define SOBEL_GRADIENT_MAGNITUDE_DIRECTION_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define SGMD_ASSERT_NOW(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sgmd assertion failed");

// consequent must hold in the cycle after the antecedent
`define SGMD_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sgmd assertion failed");

`endif

// ===== hw/rtl/sgmd_pkg.sv =====
package sgmd_pkg;

    // frame limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int MIN_DIM    = 3;

    // field and register widths
    localparam int PIX_W      = 8;
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int MAG_W      = 8;
    localparam int DIR_W      = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    // counters and limit compares
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int WLIM_W = (FW_W > COL_W + 1) ? FW_W : COL_W + 1;
    localparam int HLIM_W = (FH_W > ROW_W + 1) ? FH_W : ROW_W + 1;
    localparam int LINE_W = 2 * PIX_W;

    // gradient and root arithmetic
    localparam int SUM_W      = PIX_W + 2;
    localparam int GRAD_W     = SUM_W + 1;
    localparam int ABS_W      = SUM_W;
    localparam int SQIN_W     = ABS_W + 1;
    localparam int SQ_W       = 2 * SQIN_W;
    localparam int ROOT_STEPS = SQ_W / 2;
    localparam int ROOT_W     = ROOT_STEPS;
    localparam int REM_W      = ROOT_W + 1;
    localparam int STEP_W     = $clog2(ROOT_STEPS);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(640);
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(480);

    // direction sectors
    localparam logic [DIR_W-1:0] DIR_0   = DIR_W'(0);
    localparam logic [DIR_W-1:0] DIR_P45 = DIR_W'(1);
    localparam logic [DIR_W-1:0] DIR_90  = DIR_W'(2);
    localparam logic [DIR_W-1:0] DIR_M45 = DIR_W'(3);

    // gradient pair handed from the line buffer to the magnitude engine
    typedef struct packed {
        logic                     valid;
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic                     last;
    } grad_t;

    // finished result from the magnitude engine
    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic [DIR_W-1:0] direction;
        logic             last_in_frame;
    } result_t;

endpackage

// ===== hw/rtl/sgmd_ram.sv =====
module sgmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/sgmd_line_buf.sv =====
module sgmd_line_buf (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [sgmd_pkg::PIX_W-1:0]     s_pixel,
    input  logic [sgmd_pkg::WLIM_W-1:0]    frame_w,
    input  logic [sgmd_pkg::HLIM_W-1:0]    frame_h,
    input  logic                           eng_ready,
    output sgmd_pkg::grad_t                grad
);

    import sgmd_pkg::*;

    typedef enum logic [1:0] {
        LB_IDLE = 2'b01,
        LB_READ = 2'b10
    } lb_state_t;

    lb_state_t state_reg, state_next;

    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [PIX_W-1:0]  win_left_reg   [3];
    logic [PIX_W-1:0]  win_centre_reg [3];
    logic [PIX_W-1:0]  pix_reg;
    logic [COL_W-1:0]  addr_reg;
    logic              emit_reg;
    logic              last_reg;

    logic              accept;
    logic [WLIM_W-1:0] col_ext;
    logic [HLIM_W-1:0] row_ext;
    logic              col_wrap;
    logic              row_wrap;
    logic [LINE_W-1:0] rd_data;
    logic [PIX_W-1:0]  top_px;
    logic [PIX_W-1:0]  mid_px;
    logic [PIX_W-1:0]  bot_px;
    logic [SUM_W-1:0]  right_sum;
    logic [SUM_W-1:0]  left_sum;
    logic [SUM_W-1:0]  upper_sum;
    logic [SUM_W-1:0]  lower_sum;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == LB_IDLE) && eng_ready;

    // position limits
    assign col_ext  = WLIM_W'(col_reg);
    assign row_ext  = HLIM_W'(row_reg);
    assign col_wrap = (col_ext + WLIM_W'(1)) >= frame_w;
    assign row_wrap = (row_ext + HLIM_W'(1)) >= frame_h;

    // one read at accept, write back of the shifted column in the cycle after
    sgmd_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (state_reg == LB_READ),
        .wr_addr (addr_reg),
        .wr_data ({mid_px, pix_reg}),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (rd_data)
    );

    // right column of the window
    assign top_px = rd_data[LINE_W-1:PIX_W];
    assign mid_px = rd_data[PIX_W-1:0];
    assign bot_px = pix_reg;

    // sobel sums
    assign right_sum = SUM_W'(top_px) + (SUM_W'(mid_px) << 1) + SUM_W'(bot_px);
    assign left_sum  = SUM_W'(win_left_reg[0]) + (SUM_W'(win_left_reg[1]) << 1)
                     + SUM_W'(win_left_reg[2]);
    assign upper_sum = SUM_W'(win_left_reg[0]) + (SUM_W'(win_centre_reg[0]) << 1)
                     + SUM_W'(top_px);
    assign lower_sum = SUM_W'(win_left_reg[2]) + (SUM_W'(win_centre_reg[2]) << 1)
                     + SUM_W'(bot_px);

    assign grad.valid = (state_reg == LB_READ) && emit_reg;
    assign grad.gx    = $signed({1'b0, right_sum}) - $signed({1'b0, left_sum});
    assign grad.gy    = $signed({1'b0, upper_sum}) - $signed({1'b0, lower_sum});
    assign grad.last  = last_reg;

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            LB_IDLE: begin
                if (accept) begin
                    state_next = LB_READ;
                end
            end
            LB_READ: begin
                state_next = LB_IDLE;
            end
            default: begin
                state_next = LB_IDLE;
            end
        endcase
    end

    // counters and window
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= LB_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            for (int i = 0; i < 3; i++) begin
                win_left_reg[i]   <= '0;
                win_centre_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (accept) begin
                if (col_wrap) begin
                    col_reg <= '0;
                    row_reg <= row_wrap ? '0 : row_reg + ROW_W'(1);
                end else begin
                    col_reg <= col_reg + COL_W'(1);
                end
            end
            if (state_reg == LB_READ) begin
                for (int i = 0; i < 3; i++) begin
                    win_left_reg[i] <= win_centre_reg[i];
                end
                win_centre_reg[0] <= top_px;
                win_centre_reg[1] <= mid_px;
                win_centre_reg[2] <= bot_px;
            end
        end
    end

    // item capture
    always_ff @(posedge aclk) begin
        if (accept) begin
            pix_reg  <= s_pixel;
            addr_reg <= col_reg;
            emit_reg <= (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));
            last_reg <= (row_ext == frame_h - HLIM_W'(1)) && (col_ext == frame_w - WLIM_W'(1));
        end
    end

endmodule

// ===== hw/rtl/sgmd_mag.sv =====
module sgmd_mag (
    input  logic               aclk,
    input  logic               aresetn,
    input  sgmd_pkg::grad_t    grad,
    output logic               eng_ready,
    output logic               res_valid,
    input  logic               res_ready,
    output sgmd_pkg::result_t  res
);

    import sgmd_pkg::*;

    typedef enum logic [3:0] {
        MG_IDLE = 4'b0001,
        MG_SQR  = 4'b0010,
        MG_ROOT = 4'b0100,
        MG_DONE = 4'b1000
    } mg_state_t;

    // squarer operand order
    localparam logic [1:0] SQ_AX   = 2'd0;
    localparam logic [1:0] SQ_AY   = 2'd1;
    localparam logic [1:0] SQ_SUM  = 2'd2;
    localparam logic [1:0] SQ_DIFF = 2'd3;

    mg_state_t state_reg, state_next;

    logic [1:0]        idx_reg;
    logic [STEP_W-1:0] step_reg;
    logic [ABS_W-1:0]  ax_reg;
    logic [ABS_W-1:0]  ay_reg;
    logic              gx_zero_reg;
    logic              same_sign_reg;
    logic              ay_gt_ax_reg;
    logic              last_reg;
    logic [SQ_W-1:0]   gx2_reg;
    logic [SQ_W-1:0]   gy2_reg;
    logic [SQ_W-1:0]   s2_reg;
    logic [SQ_W-1:0]   d2_reg;
    logic [SQ_W-1:0]   rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;

    logic [ABS_W-1:0]   ax;
    logic [ABS_W-1:0]   ay;
    logic               gx_pos;
    logic               gy_pos;
    logic [SQIN_W-1:0]  sq_in;
    logic [SQ_W-1:0]    sq_prod;
    logic [REM_W+1:0]   cur;
    logic [REM_W+1:0]   trial;
    logic               ge;
    logic [SQ_W-1:0]    twice_gx2;
    logic [DIR_W-1:0]   sector;

    assign eng_ready = (state_reg == MG_IDLE);
    assign res_valid = (state_reg == MG_DONE);

    // operand conditioning
    assign ax     = grad.gx[GRAD_W-1] ? ABS_W'(-grad.gx) : ABS_W'(grad.gx);
    assign ay     = grad.gy[GRAD_W-1] ? ABS_W'(-grad.gy) : ABS_W'(grad.gy);
    assign gx_pos = !grad.gx[GRAD_W-1] && (grad.gx != '0);
    assign gy_pos = !grad.gy[GRAD_W-1] && (grad.gy != '0);

    // shared squarer
    always_comb begin
        case (idx_reg)
            SQ_AX:   sq_in = SQIN_W'(ax_reg);
            SQ_AY:   sq_in = SQIN_W'(ay_reg);
            SQ_SUM:  sq_in = SQIN_W'(ax_reg) + SQIN_W'(ay_reg);
            SQ_DIFF: sq_in = ay_gt_ax_reg ? SQIN_W'(ay_reg - ax_reg) : '0;
            default: sq_in = '0;
        endcase
    end
    assign sq_prod = SQ_W'(sq_in) * SQ_W'(sq_in);

    // one root digit per cycle
    assign cur   = {rem_reg, rad_reg[SQ_W-1 -: 2]};
    assign trial = {1'b0, root_reg, 2'b01};
    assign ge    = cur >= trial;

    // sector tests against tan 22.5 and tan 67.5
    assign twice_gx2 = {gx2_reg[SQ_W-2:0], 1'b0};
    always_comb begin
        if (gx_zero_reg) begin
            sector = DIR_90;
        end else if (s2_reg < twice_gx2) begin
            sector = DIR_0;
        end else if (ay_gt_ax_reg && (d2_reg > twice_gx2)) begin
            sector = DIR_90;
        end else if (same_sign_reg) begin
            sector = DIR_P45;
        end else begin
            sector = DIR_M45;
        end
    end

    assign res.magnitude     = (|root_reg[ROOT_W-1:MAG_W]) ? {MAG_W{1'b1}}
                                                           : root_reg[MAG_W-1:0];
    assign res.direction     = sector;
    assign res.last_in_frame = last_reg;

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            MG_IDLE: begin
                if (grad.valid) begin
                    state_next = MG_SQR;
                end
            end
            MG_SQR: begin
                if (idx_reg == SQ_DIFF) begin
                    state_next = MG_ROOT;
                end
            end
            MG_ROOT: begin
                if (step_reg == STEP_W'(ROOT_STEPS - 1)) begin
                    state_next = MG_DONE;
                end
            end
            MG_DONE: begin
                if (res_ready) begin
                    state_next = MG_IDLE;
                end
            end
            default: begin
                state_next = MG_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MG_IDLE;
            idx_reg   <= '0;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == MG_IDLE) begin
                idx_reg  <= SQ_AX;
                step_reg <= '0;
            end
            if (state_reg == MG_SQR) begin
                idx_reg <= idx_reg + 2'd1;
            end
            if (state_reg == MG_ROOT) begin
                step_reg <= step_reg + STEP_W'(1);
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if ((state_reg == MG_IDLE) && grad.valid) begin
            ax_reg        <= ax;
            ay_reg        <= ay;
            gx_zero_reg   <= (grad.gx == '0);
            same_sign_reg <= (gx_pos == gy_pos);
            ay_gt_ax_reg  <= (ay > ax);
            last_reg      <= grad.last;
        end
        if (state_reg == MG_SQR) begin
            case (idx_reg)
                SQ_AX:   gx2_reg <= sq_prod;
                SQ_AY:   gy2_reg <= sq_prod;
                SQ_SUM:  s2_reg  <= sq_prod;
                SQ_DIFF: d2_reg  <= sq_prod;
                default: d2_reg  <= sq_prod;
            endcase
            if (idx_reg == SQ_DIFF) begin
                rad_reg  <= gx2_reg + gy2_reg;
                rem_reg  <= '0;
                root_reg <= '0;
            end
        end
        if (state_reg == MG_ROOT) begin
            rem_reg  <= ge ? REM_W'(cur - trial) : REM_W'(cur);
            root_reg <= {root_reg[ROOT_W-2:0], ge};
            rad_reg  <= rad_reg << 2;
        end
    end

endmodule

// ===== hw/rtl/sobel_gradient_magnitude_direction_top.sv =====
// 3x3 sobel gradient magnitude and direction sector over a raster pixel stream
//
// input channel s_valid/s_ready/s_pixel takes one 8-bit pixel per item in
// raster order, frame after frame. result channel m_valid/m_ready carries
// m_magnitude (floor of gradient length, saturated at 255), m_direction
// (0 near 0 deg, 1 near +45, 2 near 90, 3 near -45) and m_last_in_frame.
// only interior pixels (row and column both at least 2) give a result.
// frame width and height are set on the cfg_wr_en/cfg_index/cfg_wdata port
// only while the block is idle, a rule for the user that the block does not
// enforce; out-of-range values are clamped to [3, max]. each item reads and
// writes back one entry of a 16-bit line memory that holds the two rows above.
// a border pixel passes only the memory access and window; an interior pixel
// also passes the shared squarer, the one-digit-per-cycle root and the load
// into the output register. the next pixel is taken once the result sits
// there, so a stalled receiver holds at most one result there and one in the
// engine, and then blocks the input. reset clears counters, window and valids;
// the line memory is not cleared and is refilled by the first two rows.
`include "sobel_gradient_magnitude_direction_top_assert.svh"

module sobel_gradient_magnitude_direction_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [sgmd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sgmd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [sgmd_pkg::PIX_W-1:0]        s_pixel,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [sgmd_pkg::MAG_W-1:0]        m_magnitude,
    output logic [sgmd_pkg::DIR_W-1:0]        m_direction,
    output logic                              m_last_in_frame
);

    import sgmd_pkg::*;

    logic [FW_W-1:0]   frame_width_reg;
    logic [FH_W-1:0]   frame_height_reg;
    logic [WLIM_W-1:0] fw_ext;
    logic [HLIM_W-1:0] fh_ext;
    logic [WLIM_W-1:0] frame_w;
    logic [HLIM_W-1:0] frame_h;

    grad_t             grad;
    logic              eng_ready;
    logic              res_valid;
    logic              res_ready;
    result_t           res;

    logic              m_valid_reg;
    result_t           m_res_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[FW_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata[FH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // clamp frame size into the supported range
    assign fw_ext  = WLIM_W'(frame_width_reg);
    assign fh_ext  = HLIM_W'(frame_height_reg);
    assign frame_w = (fw_ext < WLIM_W'(MIN_DIM))   ? WLIM_W'(MIN_DIM)
                   : (fw_ext > WLIM_W'(MAX_WIDTH))  ? WLIM_W'(MAX_WIDTH)  : fw_ext;
    assign frame_h = (fh_ext < HLIM_W'(MIN_DIM))   ? HLIM_W'(MIN_DIM)
                   : (fh_ext > HLIM_W'(MAX_HEIGHT)) ? HLIM_W'(MAX_HEIGHT) : fh_ext;

    sgmd_line_buf u_line_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_pixel   (s_pixel),
        .frame_w   (frame_w),
        .frame_h   (frame_h),
        .eng_ready (eng_ready),
        .grad      (grad)
    );

    sgmd_mag u_mag (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .grad      (grad),
        .eng_ready (eng_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_magnitude     = m_res_reg.magnitude;
    assign m_direction     = m_res_reg.direction;
    assign m_last_in_frame = m_res_reg.last_in_frame;

    // checks
    `SGMD_ASSERT_NEXT(a_result_loaded, aclk, aresetn, res_valid && res_ready, m_valid_reg)
    `SGMD_ASSERT_NEXT(a_single_item, aclk, aresetn, s_valid && s_ready, !s_ready)
    `SGMD_ASSERT_NOW(a_no_take_while_pending, aclk, aresetn, res_valid, !s_ready)

endmodule

// ===== sim/sgmd_gradient_checker.sv =====
`timescale 1ns / 1ps

// watches both channels and the register port, predicts every gradient result
// and compares what leaves the block against it
module sgmd_gradient_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [sgmd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sgmd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic [sgmd_pkg::PIX_W-1:0]      s_pixel,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [sgmd_pkg::MAG_W-1:0]      m_magnitude,
    input  logic [sgmd_pkg::DIR_W-1:0]      m_direction,
    input  logic                            m_last_in_frame,
    output int                              mismatches,
    output int                              outstanding,
    output int                              results_seen
);

    import sgmd_pkg::*;

    localparam int MAX_REPORTS = 200;

    // register copies
    logic [FW_W-1:0]  row_width;
    logic [FH_W-1:0]  frame_rows;

    // two rows above the incoming pixel, and the two previous window columns
    logic [PIX_W-1:0] older_line [MAX_WIDTH];
    logic [PIX_W-1:0] newer_line [MAX_WIDTH];
    int               left_col [3];
    int               centre_col [3];
    int unsigned      col_pos;
    int unsigned      row_pos;

    result_t          expected_gradients [$];

    // register value as the block uses it
    function automatic int unsigned limit_dim(input int unsigned value, input int unsigned top);
        if (value < MIN_DIM) begin
            return MIN_DIM;
        end
        if (value > top) begin
            return top;
        end
        return value;
    endfunction

    // integer square root, one result bit at a time from the top
    function automatic int floor_root(input int value);
        int root;
        int trial;
        int b;
        root = 0;
        for (b = 11; b >= 0; b--) begin
            trial = root | (1 << b);
            if (trial * trial <= value) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // sector boundaries at tan 22.5 and tan 67.5, tested exactly in integers
    function automatic logic [DIR_W-1:0] angle_sector(input int gx, input int gy);
        int ax;
        int ay;
        if (gx == 0) begin
            return DIR_90;
        end
        ax = (gx < 0) ? -gx : gx;
        ay = (gy < 0) ? -gy : gy;
        if ((ax + ay) * (ax + ay) < 2 * ax * ax) begin
            return DIR_0;
        end
        if (ay > ax && (ay - ax) * (ay - ax) > 2 * ax * ax) begin
            return DIR_90;
        end
        return ((gx > 0) == (gy > 0)) ? DIR_P45 : DIR_M45;
    endfunction

    // one accepted pixel: maybe one result, then shift the window and count
    task automatic predict_gradient(input logic [PIX_W-1:0] pixel);
        int unsigned w;
        int unsigned h;
        int unsigned slot;
        int          up;
        int          mid;
        int          low;
        int          gx;
        int          gy;
        int          mag;
        result_t     item;
        w    = limit_dim(row_width, MAX_WIDTH);
        h    = limit_dim(frame_rows, MAX_HEIGHT);
        slot = col_pos % MAX_WIDTH;
        up   = older_line[slot];
        mid  = newer_line[slot];
        low  = pixel;

        if (row_pos >= 2 && col_pos >= 2) begin
            gx = (up + 2 * mid + low) - (left_col[0] + 2 * left_col[1] + left_col[2]);
            gy = (left_col[0] + 2 * centre_col[0] + up)
               - (left_col[2] + 2 * centre_col[2] + low);
            mag = floor_root(gx * gx + gy * gy);
            item.magnitude     = (mag > 255) ? '1 : MAG_W'(mag);
            item.direction     = angle_sector(gx, gy);
            item.last_in_frame = (row_pos == h - 1 && col_pos == w - 1);
            expected_gradients.insert(expected_gradients.size(), item);
        end

        older_line[slot] = newer_line[slot];
        newer_line[slot] = pixel;
        left_col         = centre_col;
        centre_col[0]    = up;
        centre_col[1]    = mid;
        centre_col[2]    = low;

        // counters wrap when they reach or pass the limit
        if (col_pos + 1 >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end else begin
            col_pos++;
        end
    endtask

    // compare first, then register writes, then prediction
    always @(posedge aclk) begin : model_update
        result_t want;
        if (!aresetn) begin
            row_width  = FRAME_WIDTH_RST;
            frame_rows = FRAME_HEIGHT_RST;
            foreach (older_line[k]) begin
                older_line[k] = '0;
                newer_line[k] = '0;
            end
            left_col     = '{0, 0, 0};
            centre_col   = '{0, 0, 0};
            col_pos      = 0;
            row_pos      = 0;
            expected_gradients.delete();
            mismatches   = 0;
            outstanding  = 0;
            results_seen = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_gradients.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t: result with nothing expected, got magnitude %0d",
                                 $time, m_magnitude);
                        $display("%0t: direction %0d last %0b",
                                 $time, m_direction, m_last_in_frame);
                    end
                end else begin
                    want = expected_gradients.pop_front();
                    results_seen++;
                    if (m_magnitude !== want.magnitude) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("%0t: magnitude expected %0d, got %0d",
                                     $time, want.magnitude, m_magnitude);
                        end
                    end
                    if (m_direction !== want.direction) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("%0t: direction expected %0d, got %0d",
                                     $time, want.direction, m_direction);
                        end
                    end
                    if (m_last_in_frame !== want.last_in_frame) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("%0t: last_in_frame expected %0b, got %0b",
                                     $time, want.last_in_frame, m_last_in_frame);
                        end
                    end
                end
                if (mismatches > MAX_REPORTS && mismatches - MAX_REPORTS <= 3) begin
                    $display("%0t: further mismatches counted but not shown", $time);
                end
            end

            if (cfg_wr_en) begin
                if (cfg_index == REG_FRAME_WIDTH) begin
                    row_width = cfg_wdata[FW_W-1:0];
                end else if (cfg_index == REG_FRAME_HEIGHT) begin
                    frame_rows = cfg_wdata[FH_W-1:0];
                end
            end

            if (s_valid && s_ready) begin
                predict_gradient(s_pixel);
            end

            outstanding = expected_gradients.size();
        end
    end

endmodule

// ===== sim/tb_sobel_gradient_magnitude_direction_top.sv =====
`timescale 1ns / 1ps

module tb_sobel_gradient_magnitude_direction_top;
    import sgmd_pkg::*;

    localparam int IDLE_PCT      = 22;
    localparam int SETTLE_CYCLES = 24;
    localparam int RANDOM_PIXELS = 700;
    localparam int BATCH_MAX     = 300;
    localparam int CALM_FROM     = 150;
    localparam int CALM_TO       = 450;

    typedef enum int {TEX_NOISE, TEX_BINARY, TEX_RAMP, TEX_FLAT} texture_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic [PIX_W-1:0]      s_pixel   = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic [MAG_W-1:0]      m_magnitude;
    logic [DIR_W-1:0]      m_direction;
    logic                  m_last_in_frame;

    // no idling on either side while set
    logic                  calm      = 1'b0;

    int mismatches;
    int outstanding;
    int results_seen;
    int pixels_sent     = 0;
    int register_writes = 0;

    // clock
    initial begin
        forever #2 aclk = ~aclk;
    end

    sobel_gradient_magnitude_direction_top u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pixel         (s_pixel),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_magnitude     (m_magnitude),
        .m_direction     (m_direction),
        .m_last_in_frame (m_last_in_frame)
    );

    sgmd_gradient_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pixel         (s_pixel),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_magnitude     (m_magnitude),
        .m_direction     (m_direction),
        .m_last_in_frame (m_last_in_frame),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_seen    (results_seen)
    );

    // result side stalls at random
    always @(posedge aclk) begin
        m_ready <= calm ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end

    // one pixel item, with random gaps before it
    task automatic push_pixel(input logic [PIX_W-1:0] value);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel <= value;
        do @(posedge aclk); while (!s_ready);
        pixels_sent++;
    endtask

    // all results in, then let any border pixel still in flight finish
    task automatic drain_and_wait();
        s_valid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // both registers, only with the block idle
    task automatic configure(input logic [CFG_DATA_W-1:0] width_word,
                             input logic [CFG_DATA_W-1:0] height_word);
        drain_and_wait();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_wdata <= width_word;
        @(posedge aclk);
        cfg_index <= REG_FRAME_HEIGHT;
        cfg_wdata <= height_word;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        register_writes += 2;
    endtask

    function automatic logic [PIX_W-1:0] texel(input texture_t tex, input int row, input int col,
                                               input int base, input int sx, input int sy);
        case (tex)
            TEX_BINARY: begin
                return $urandom_range(1) ? '1 : '0;
            end
            TEX_RAMP: begin
                return PIX_W'(base + col * sx + row * sy + int'($urandom_range(3)));
            end
            TEX_FLAT: begin
                return PIX_W'(base + (($urandom_range(9) == 0) ? 1 : 0));
            end
            default: begin
                return PIX_W'($urandom_range(255));
            end
        endcase
    endfunction

    // whole frames, so the counters end at the frame origin
    task automatic send_frames(input int fw, input int fh, input int count, input texture_t tex);
        int f;
        int r;
        int c;
        int base;
        int sx;
        int sy;
        for (f = 0; f < count; f++) begin
            base = $urandom_range(255);
            sx   = $urandom_range(40);
            sy   = $urandom_range(40);
            sx  -= 20;
            sy  -= 20;
            for (r = 0; r < fh; r++) begin
                for (c = 0; c < fw; c++) begin
                    push_pixel(texel(tex, r, c, base, sx, sy));
                end
            end
        end
    endtask

    // stimulus
    initial begin
        int                    i;
        int                    fw;
        int                    fh;
        int                    frames;
        int                    random_pixels;
        logic [CFG_DATA_W-1:0] width_word;
        logic [CFG_DATA_W-1:0] height_word;
        texture_t              tex;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // reset geometry of 640 wide: one full row and part of the next,
        // then a narrower width and shorter frame mid-row, finishing that frame
        for (i = 0; i < 640 + 8; i++) begin
            push_pixel(PIX_W'($urandom_range(255)));
        end
        configure(CFG_DATA_W'(16), CFG_DATA_W'(4));
        for (i = 0; i < 40; i++) begin
            push_pixel(PIX_W'($urandom_range(255)));
        end

        // zero registers clamp to 3x3: flat, vertical edge, horizontal edge
        configure('0, '0);
        repeat (9) push_pixel('0);
        for (i = 0; i < 9; i++) begin
            push_pixel((i % 3 == 2) ? '1 : '0);
        end
        for (i = 0; i < 9; i++) begin
            push_pixel((i < 3) ? '1 : '0);
        end

        // tallest frame, cut short by a smaller height mid-frame
        configure(CFG_DATA_W'(3), '1);
        for (i = 0; i < 60; i++) begin
            push_pixel(PIX_W'($urandom_range(255)));
        end
        configure(CFG_DATA_W'(3), CFG_DATA_W'(5));
        for (i = 0; i < 18; i++) begin
            push_pixel(PIX_W'($urandom_range(255)));
        end

        // width shrunk below the running column
        configure(CFG_DATA_W'(8), CFG_DATA_W'(6));
        for (i = 0; i < 21; i++) begin
            push_pixel(PIX_W'($urandom_range(255)));
        end
        configure(CFG_DATA_W'(4), CFG_DATA_W'(6));
        for (i = 0; i < 13; i++) begin
            push_pixel(PIX_W'($urandom_range(255)));
        end

        // random geometry and texture, mostly small frames
        random_pixels = 0;
        while (random_pixels < RANDOM_PIXELS) begin
            i = $urandom_range(99);
            if (i < 70) begin
                fw = $urandom_range(10, 3);
            end else if (i < 95) begin
                fw = $urandom_range(40, 11);
            end else begin
                fw = $urandom_range(120, 41);
            end
            if (fw > 40) begin
                fh     = $urandom_range(5, 3);
                frames = 1;
            end else begin
                fh     = ($urandom_range(99) < 80) ? $urandom_range(8, 3) : $urandom_range(24, 9);
                frames = $urandom_range(2, 1);
            end
            // keep one batch small against the item budget
            if (fw <= 40 && fw * fh * frames > BATCH_MAX) begin
                frames = 1;
                fh     = MIN_DIM + 2;
            end
            tex = texture_t'($urandom_range(3));

            width_word = {2'($urandom), 11'(fw)};
            if (fw == MIN_DIM && $urandom_range(3) == 0) begin
                width_word[FW_W-1:0] = FW_W'($urandom_range(2));
            end
            height_word = CFG_DATA_W'(fh);
            if (fh == MIN_DIM && $urandom_range(3) == 0) begin
                height_word = CFG_DATA_W'($urandom_range(2));
            end

            configure(width_word, height_word);
            calm <= (random_pixels >= CALM_FROM && random_pixels < CALM_TO);
            send_frames(fw, fh, frames, tex);
            random_pixels += fw * fh * frames;
        end

        drain_and_wait();
        $display("%0d pixels over %0d register writes: reset geometry, clamped sizes,",
                 pixels_sent, register_writes);
        $display("mid-frame resizes and random frames up to 120 wide");
        $display("%0d gradient results compared, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // overall time limit, 10 ms
    initial begin
        #(10_000_000);
        $display("run timed out with %0d results still expected", outstanding);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sobel_gradient_magnitude_direction_top.f =====
+incdir+hw/rtl
hw/rtl/sgmd_pkg.sv
hw/rtl/sgmd_ram.sv
hw/rtl/sgmd_line_buf.sv
hw/rtl/sgmd_mag.sv
hw/rtl/sobel_gradient_magnitude_direction_top.sv
sim/sgmd_gradient_checker.sv
sim/tb_sobel_gradient_magnitude_direction_top.sv
